// ===== hdl/fsc_pkg.sv =====
package fsc_pkg;

  localparam int DATA_W            = 15;
  localparam int FRAC_BITS_DEFAULT = 8;

  localparam int SAT_LIMIT = 45;
  localparam int EDGE_IN   = 3;
  localparam int EDGE_OUT  = 4;

  // Centroid sums over the points -40..40, folded per membership term.
  localparam int DEN_NEG  = 128;
  localparam int DEN_NB   = 12;
  localparam int DEN_MED  = 32;
  localparam int DEN_PB   = 12;
  localparam int DEN_POS  = 132;
  localparam int NUM_NEG  = 3136;
  localparam int NUM_NB   = 80;
  localparam int NUM_MED  = 16;
  localparam int NUM_PB   = 64;
  localparam int NUM_POS  = 3168;

  typedef struct packed {
    logic neg;
    logic zero;
  } fsc_flags_t;

endpackage

// ===== hdl/fsc_fuzzify.sv =====
module fsc_fuzzify #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic signed [fsc_pkg::DATA_W-1:0]    up_diff,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic [FRAC_BITS+8:0]                 dn_rem,
  output logic [FRAC_BITS+8:0]                 dn_dvs,
  output logic [FRAC_BITS+5:0]                 dn_dend,
  output fsc_pkg::fsc_flags_t                  dn_flags
);
  import fsc_pkg::*;

  localparam int SW  = FRAC_BITS + 10;
  localparam int MW  = FRAC_BITS + 1;
  localparam int DNW = FRAC_BITS + 8;
  localparam int NW  = FRAC_BITS + 13;
  localparam int DW  = 2 * FRAC_BITS + 14;
  localparam int QW  = FRAC_BITS + 6;
  localparam int DVW = FRAC_BITS + 9;

  localparam logic signed [SW-1:0] ONE  = SW'(1 << FRAC_BITS);
  localparam logic signed [SW-1:0] T3   = SW'(EDGE_IN << FRAC_BITS);
  localparam logic signed [SW-1:0] T4   = SW'(EDGE_OUT << FRAC_BITS);
  localparam logic signed [SW-1:0] T45  = SW'(SAT_LIMIT << FRAC_BITS);
  localparam logic signed [SW-1:0] NT3  = -T3;
  localparam logic signed [SW-1:0] NT4  = -T4;
  localparam logic signed [SW-1:0] NT45 = -T45;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  logic signed [SW-1:0] xs;
  logic [MW-1:0] pos_c, neg_c, med_c;
  logic [MW-1:0] pos1, neg1, med1;
  logic [MW-1:0] pos2, neg2, med2, mn2, mp2;
  logic [DNW-1:0] den3;
  logic [NW-1:0] num3;
  logic [NW-1:0] num_abs;
  logic [NW-2:0] mag;
  logic [DW-1:0] dividend;

  assign r4 = ~v4 | dn_ready;
  assign r3 = ~v3 | r4;
  assign r2 = ~v2 | r3;
  assign r1 = ~v1 | r2;
  assign up_ready = r1;
  assign dn_valid = v4;

  always_comb begin
    xs = SW'(up_diff);
    if (xs > T45) begin
      xs = T45;
    end else if (xs < NT45) begin
      xs = NT45;
    end

    pos_c = '0;
    if (xs >= T3 && xs <= T4) begin
      pos_c = MW'(xs - T3);
    end else if (xs > T4) begin
      pos_c = MW'(ONE);
    end

    neg_c = '0;
    if (xs <= NT4) begin
      neg_c = MW'(ONE);
    end else if (xs <= NT3) begin
      neg_c = MW'(NT3 - xs);
    end

    med_c = '0;
    if (xs >= NT4 && xs <= NT3) begin
      med_c = MW'(xs - NT4);
    end else if (xs > NT3 && xs <= T3) begin
      med_c = MW'(ONE);
    end else if (xs > T3 && xs <= T4) begin
      med_c = MW'(T4 - xs);
    end
  end

  assign num_abs  = num3[NW-1] ? -num3 : num3;
  assign mag      = num_abs[NW-2:0];
  assign dividend = (DW'(mag) << (FRAC_BITS + 1)) + DW'(den3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= up_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end

    if (r1) begin
      pos1 <= pos_c;
      neg1 <= neg_c;
      med1 <= med_c;
    end

    if (r2) begin
      pos2 <= pos1;
      neg2 <= neg1;
      med2 <= med1;
      mn2  <= (med1 <= neg1) ? med1 : neg1;
      mp2  <= (med1 <= pos1) ? med1 : pos1;
    end

    if (r3) begin
      den3 <= DNW'(neg2) * DNW'(DEN_NEG) + DNW'(mn2) * DNW'(DEN_NB)
            + DNW'(med2) * DNW'(DEN_MED) + DNW'(mp2) * DNW'(DEN_PB)
            + DNW'(pos2) * DNW'(DEN_POS);
      num3 <= (NW'(pos2) * NW'(NUM_POS) + NW'(mp2) * NW'(NUM_PB))
            - (NW'(neg2) * NW'(NUM_NEG) + NW'(mn2) * NW'(NUM_NB)
               + NW'(med2) * NW'(NUM_MED));
    end

    if (r4) begin
      dn_rem        <= DVW'(dividend[DW-1:QW]);
      dn_dend       <= dividend[QW-1:0];
      dn_dvs        <= {den3, 1'b0};
      dn_flags.neg  <= num3[NW-1];
      dn_flags.zero <= (den3 == '0);
    end
  end

endmodule

// ===== hdl/fsc_cell.sv =====
module fsc_cell #(
  parameter int DVW = 17,
  parameter int QW  = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [DVW-1:0]       up_rem,
  input  logic [DVW-1:0]       up_dvs,
  input  logic [QW-1:0]        up_dend,
  input  logic [QW-1:0]        up_quo,
  input  fsc_pkg::fsc_flags_t  up_flags,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [DVW-1:0]       dn_rem,
  output logic [DVW-1:0]       dn_dvs,
  output logic [QW-1:0]        dn_dend,
  output logic [QW-1:0]        dn_quo,
  output fsc_pkg::fsc_flags_t  dn_flags
);
  import fsc_pkg::*;

  logic [DVW:0] rem_sh;
  logic [DVW:0] rem_sub;
  logic         take;

  assign up_ready = ~dn_valid | dn_ready;

  assign rem_sh  = {up_rem, up_dend[QW-1]};
  assign take    = (rem_sh >= {1'b0, up_dvs});
  assign rem_sub = rem_sh - {1'b0, up_dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end

    if (up_ready) begin
      dn_rem   <= take ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
      dn_dvs   <= up_dvs;
      dn_dend  <= {up_dend[QW-2:0], 1'b0};
      dn_quo   <= {up_quo[QW-2:0], take};
      dn_flags <= up_flags;
    end
  end

endmodule

// ===== hdl/fuzzy_steering_controller.sv =====
// Fuzzy steering controller with centroid defuzzification.
// The input channel (distance_valid, distance_ready, distance_diff) takes one
// signed right-minus-left distance per item in fixed point with FRAC_BITS
// fraction bits. The output channel (steer_valid, steer_ready, steer_angle)
// returns one steering angle per item in the same format.
// A front end of four register stages clamps the input, forms the three
// memberships and folds the centroid sums into a numerator and a denominator.
// A row of FRAC_BITS + 6 divider cells then produces one quotient bit each,
// and a final register applies the sign. Every stage holds its own valid bit,
// so one item can enter in every cycle unless the row is stalled, and empty
// stages close up while the receiver stalls. When steer_ready stays low the
// row fills and distance_ready falls only once every stage holds an item.
// Synchronous reset empties all stages.
module fuzzy_steering_controller #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               distance_valid,
  output logic                               distance_ready,
  input  logic signed [fsc_pkg::DATA_W-1:0]  distance_diff,
  output logic                               steer_valid,
  input  logic                               steer_ready,
  output logic signed [fsc_pkg::DATA_W-1:0]  steer_angle
);
  import fsc_pkg::*;

  localparam int QW  = FRAC_BITS + 6;
  localparam int DVW = FRAC_BITS + 9;
  localparam int EW  = (QW + 1 > DATA_W) ? QW + 1 : DATA_W;

  logic [QW:0]           c_valid;
  logic [QW:0]           c_ready;
  logic [QW:0][DVW-1:0]  c_rem;
  logic [QW:0][DVW-1:0]  c_dvs;
  logic [QW:0][QW-1:0]   c_dend;
  logic [QW:0][QW-1:0]   c_quo;
  fsc_flags_t [QW:0]     c_flags;

  logic                  out_load;
  logic signed [EW-1:0]  q_mag;
  logic signed [EW-1:0]  q_signed;

  fsc_fuzzify #(
    .FRAC_BITS(FRAC_BITS)
  ) u_fuzzify (
    .clk      (clk),
    .rst      (rst),
    .up_valid (distance_valid),
    .up_ready (distance_ready),
    .up_diff  (distance_diff),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .dn_rem   (c_rem[0]),
    .dn_dvs   (c_dvs[0]),
    .dn_dend  (c_dend[0]),
    .dn_flags (c_flags[0])
  );

  assign c_quo[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    fsc_cell #(
      .DVW(DVW),
      .QW (QW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (c_valid[k]),
      .up_ready (c_ready[k]),
      .up_rem   (c_rem[k]),
      .up_dvs   (c_dvs[k]),
      .up_dend  (c_dend[k]),
      .up_quo   (c_quo[k]),
      .up_flags (c_flags[k]),
      .dn_valid (c_valid[k+1]),
      .dn_ready (c_ready[k+1]),
      .dn_rem   (c_rem[k+1]),
      .dn_dvs   (c_dvs[k+1]),
      .dn_dend  (c_dend[k+1]),
      .dn_quo   (c_quo[k+1]),
      .dn_flags (c_flags[k+1])
    );
  end

  assign out_load    = ~steer_valid | steer_ready;
  assign c_ready[QW] = out_load;

  always_comb begin
    q_mag = EW'($signed({1'b0, c_quo[QW]}));
    if (c_flags[QW].zero) begin
      q_signed = '0;
    end else if (c_flags[QW].neg) begin
      q_signed = -q_mag;
    end else begin
      q_signed = q_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_valid <= 1'b0;
    end else if (out_load) begin
      steer_valid <= c_valid[QW];
    end

    if (out_load) begin
      steer_angle <= q_signed[DATA_W-1:0];
    end
  end

endmodule

// ===== hdl/fsc_checker.sv =====
module fsc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               distance_valid,
  input logic                               distance_ready,
  input logic signed [fsc_pkg::DATA_W-1:0]  distance_diff,
  input logic                               steer_valid,
  input logic                               steer_ready,
  input logic signed [fsc_pkg::DATA_W-1:0]  steer_angle
);
  import fsc_pkg::*;

  // Reset empties every stage, so the block comes out ready with no result.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !steer_valid && distance_ready)
    else $error("result or stall present right after reset");

  // The input side can only stall when a result is held by the receiver.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !distance_ready |-> steer_valid && !steer_ready)
    else $error("input stalled without a stalled result");

  // An input item offered while stalled is still offered, unchanged, in the next cycle.
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    distance_valid && !distance_ready |=> distance_valid && $stable(distance_diff))
    else $error("input item dropped or changed while stalled");

  // A stalled result stays in the output register unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    steer_valid && !steer_ready |=> steer_valid && $stable(steer_angle))
    else $error("stalled result changed or vanished");

endmodule

bind fuzzy_steering_controller fsc_checker u_fsc_checker (.*);

// ===== test/fuzzy_steering_controller_test.sv =====
`timescale 1ns / 1ps

module fuzzy_steering_controller_test;

  import fsc_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEFAULT;
  localparam int ONE        = 1 << FRAC;
  localparam int POINT_MIN  = -40;
  localparam int POINT_MAX  = 40;
  localparam int BAND_OUTER = 8;
  localparam int BAND_INNER = 4;
  localparam int SAT_RAW    = SAT_LIMIT * ONE;
  localparam int CALM_TAIL  = 120;
  localparam int RANDOM_ITEMS = 825;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      distance_valid = 1'b0;
  logic                      distance_ready;
  logic signed [DATA_W-1:0]  distance_diff = '0;
  logic                      steer_valid;
  logic                      steer_ready = 1'b0;
  logic signed [DATA_W-1:0]  steer_angle;

  logic signed [DATA_W-1:0]  pending_diffs[$];
  logic signed [DATA_W-1:0]  expected_angles[$];
  int total_items = 0;
  int items_sent = 0;
  int saturated_sent = 0;
  int angles_checked = 0;
  int mismatch_count = 0;
  int gap_left = 0;
  int stall_left = 0;

  fuzzy_steering_controller u_top (
    .clk            (clk),
    .rst            (rst),
    .distance_valid (distance_valid),
    .distance_ready (distance_ready),
    .distance_diff  (distance_diff),
    .steer_valid    (steer_valid),
    .steer_ready    (steer_ready),
    .steer_angle    (steer_angle)
  );

  always #5 clk = ~clk;

  function automatic longint band_quarters(input int span);
    case (span)
      8: return 4;
      7: return 3;
      6: return 2;
      5: return 3;
      default: return 4;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] centroid_angle(
    input logic signed [DATA_W-1:0] diff
  );
    longint x, pos, neg, med, num, den, w, mag, q;
    longint t3, t4, t45;
    int pt;
    t3 = EDGE_IN * ONE;
    t4 = EDGE_OUT * ONE;
    t45 = SAT_LIMIT * ONE;
    x = diff;
    pos = 0;
    neg = 0;
    med = 0;
    num = 0;
    den = 0;
    if (x > t45) x = t45;
    if (x < -t45) x = -t45;
    if (x >= t3 && x <= t4) pos = x - t3;
    else if (x > t4) pos = ONE;
    if (x <= -t4) neg = ONE;
    else if (x <= -t3) neg = -x - t3;
    if (x >= -t4 && x <= -t3) med = x + t4;
    else if (x > -t3 && x <= t3) med = ONE;
    else if (x > t3 && x <= t4) med = t4 - x;
    for (pt = POINT_MIN; pt <= POINT_MAX; pt++) begin
      if (pt < -BAND_OUTER) w = 4 * neg;
      else if (pt < -BAND_INNER) w = band_quarters(-pt) * ((med < neg) ? med : neg);
      else if (pt < BAND_INNER) w = 4 * med;
      else if (pt < BAND_OUTER) w = band_quarters(pt) * ((med < pos) ? med : pos);
      else w = 4 * pos;
      den += w;
      num += w * pt;
    end
    if (den == 0) begin
      q = 0;
    end else begin
      mag = (num < 0) ? -num : num;
      q = (2 * mag * ONE + den) / (2 * den);
      if (num < 0) q = -q;
    end
    return q[DATA_W-1:0];
  endfunction

  // Driver: one item per free slot, with random gaps until the tail of the run.
  always @(posedge clk) begin
    if (rst) begin
      distance_valid <= 1'b0;
    end else begin
      if (distance_valid && distance_ready) begin
        expected_angles.push_back(centroid_angle(distance_diff));
        items_sent++;
        if (distance_diff > SAT_RAW || distance_diff < -SAT_RAW) saturated_sent++;
      end
      if (!distance_valid || distance_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          distance_valid <= 1'b0;
        end else if (pending_diffs.size() == 0) begin
          distance_valid <= 1'b0;
        end else if (pending_diffs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 7) - 1;
          distance_valid <= 1'b0;
        end else begin
          distance_valid <= 1'b1;
          distance_diff <= pending_diffs.pop_front();
        end
      end
    end
  end

  // Monitor: checks every accepted angle and stalls the output at random.
  always @(posedge clk) begin
    if (rst) begin
      steer_ready <= 1'b0;
    end else begin
      if (steer_valid && steer_ready) begin
        if (expected_angles.size() == 0) begin
          $error("steer_angle: no item pending, got %0d", steer_angle);
          mismatch_count++;
        end else begin
          logic signed [DATA_W-1:0] exp_angle;
          exp_angle = expected_angles.pop_front();
          if (steer_angle !== exp_angle) begin
            $error("steer_angle mismatch: expected %0d, got %0d", exp_angle, steer_angle);
            mismatch_count++;
          end
        end
        angles_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        steer_ready <= 1'b0;
      end else if (angles_checked < total_items - CALM_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        steer_ready <= 1'b0;
      end else begin
        steer_ready <= 1'b1;
      end
    end
  end

  initial begin
    int edge_pts[$];
    int kind;
    logic [DATA_W-1:0] raw;
    edge_pts = '{0, 1, -1, 3 * ONE - 1, 3 * ONE, 3 * ONE + 1, -3 * ONE + 1, -3 * ONE,
                 -3 * ONE - 1, 7 * ONE / 2, -7 * ONE / 2, 4 * ONE - 1, 4 * ONE,
                 4 * ONE + 1, -4 * ONE + 1, -4 * ONE, -4 * ONE - 1, SAT_RAW - 1,
                 SAT_RAW, SAT_RAW + 1, -SAT_RAW, -SAT_RAW - 1, 16383, -16384, 10 * ONE};
    foreach (edge_pts[k]) pending_diffs.push_back(DATA_W'(edge_pts[k]));
    repeat (RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        raw = DATA_W'($urandom());
        pending_diffs.push_back(raw);
      end else if (kind < 7) begin
        pending_diffs.push_back(DATA_W'($signed($urandom_range(0, 2 * 5 * ONE)) - 5 * ONE));
      end else begin
        pending_diffs.push_back(DATA_W'($signed($urandom_range(0, 2 * SAT_RAW)) - SAT_RAW));
      end
    end
    total_items = pending_diffs.size();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pending_diffs.size() != 0 || distance_valid) @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (FRAC + 30) @(posedge clk);
    $display("Sent %0d distance items, %0d of them beyond the saturation limit.",
             items_sent, saturated_sent);
    $display("Checked %0d steering angles under random input gaps and output stalls.",
             angles_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
